// ===== hdl/sd_spi_block_reader_assert.svh =====
// Assertion macros for the SD card SPI block reader.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SD_SPI_BLOCK_READER_ASSERT_SVH
`define SD_SPI_BLOCK_READER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sdr_pkg.sv =====
// Shared types, constants and codes for the SD card SPI block reader.
// No dependencies; imported by sdr_core and sd_spi_block_reader.
package sdr_pkg;

    // Block geometry and counter widths.
    localparam int BLOCK_BYTES  = 512;
    localparam int BYTE_CNT_W   = 10;
    localparam int POLL_CNT_W   = 16;
    localparam int TRIES_W      = 4;
    localparam int CFG_DATA_W   = 16;

    // SPI byte values.
    localparam logic [7:0] CMD_START_BITS  = 8'h40;
    localparam logic [7:0] CMD_READ_SINGLE = 8'd17;
    localparam logic [7:0] CMD17_BYTE      = CMD_START_BITS | CMD_READ_SINGLE;
    localparam logic [7:0] DUMMY_BYTE      = 8'hFF;
    localparam logic [7:0] DATA_TOKEN      = 8'hFE;

    // Command byte positions within the six-byte frame.
    localparam logic [BYTE_CNT_W-1:0] CMD_ADDR_B3 = BYTE_CNT_W'(1);
    localparam logic [BYTE_CNT_W-1:0] CMD_ADDR_B2 = BYTE_CNT_W'(2);
    localparam logic [BYTE_CNT_W-1:0] CMD_ADDR_B1 = BYTE_CNT_W'(3);
    localparam logic [BYTE_CNT_W-1:0] CMD_ADDR_B0 = BYTE_CNT_W'(4);
    localparam logic [BYTE_CNT_W-1:0] CMD_CRC     = BYTE_CNT_W'(5);
    localparam logic [BYTE_CNT_W-1:0] CMD_DONE    = BYTE_CNT_W'(6);

    // Reset values of the configuration registers.
    localparam logic [POLL_CNT_W-1:0] TOKEN_LIMIT_RESET = 16'hFFFF;
    localparam logic [TRIES_W-1:0]    RESP_TRIES_RESET  = 4'd8;

    // Request kinds.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_TOKEN_LIMIT = 1'b0;
    localparam logic CFG_RESP_TRIES  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CMD   = 3'd1,
        PH_RESP  = 3'd2,
        PH_TOKEN = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRC   = 3'd5,
        PH_CLEAN = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_DONE    = 2'd1,
        ST_REJECT  = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    typedef struct packed {
        phase_t                  phase;
        logic [BYTE_CNT_W-1:0]   byte_cnt;
        logic [31:0]             cur_block;
        logic [31:0]             blocks_left;
        logic [POLL_CNT_W-1:0]   poll_cnt;
    } engine_state_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] first_block;
        logic [31:0] block_count;
        logic [7:0]  rx_byte;
    } req_item_t;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        select_level;
        logic        data_valid;
        logic [7:0]  data_byte;
        status_t     status;
    } result_item_t;

endpackage

// ===== hdl/sd_spi_block_reader.sv =====
// Top level of the SD card SPI-mode multi-block reader (CMD17 per block).
// Depends on sdr_pkg, sdr_core and sd_spi_block_reader_assert.svh.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------------
//  in      | in_valid / in_ready   | req_type, first_block, block_count, rx_byte
//  out     | out_valid / out_ready | send_valid, send_byte, select_level,
//          |                       | data_valid, data_byte, status
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each item is one SPI byte step; one item is accepted per cycle when the output flows.
// Items pass through an input register, then through the engine logic into the result register.
// The engine state updates as the item leaves the input register, so items follow back to back.
// A stalled output holds the result register and, once the input register is full, in_ready.
// Reset returns the engine to idle and loads the register defaults; cfg_ready is always high.
`include "sd_spi_block_reader_assert.svh"

module sd_spi_block_reader
    import sdr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   req_type,
    input  logic [31:0]            first_block,
    input  logic [31:0]            block_count,
    input  logic [7:0]             rx_byte,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   send_valid,
    output logic [7:0]             send_byte,
    output logic                   select_level,
    output logic                   data_valid,
    output logic [7:0]             data_byte,
    output logic [1:0]             status,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                   s1_valid_reg;
    req_item_t              s1_item_reg;
    logic                   out_valid_reg;
    result_item_t           result_reg;
    engine_state_t          state_reg;
    engine_state_t          state_next;
    result_item_t           result_next;
    logic [POLL_CNT_W-1:0]  token_limit_reg;
    logic [TRIES_W-1:0]     resp_tries_reg;
    logic                   s1_move;

    // Pipeline flow control.
    assign s1_move   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s1_move;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_limit_reg <= TOKEN_LIMIT_RESET;
            resp_tries_reg  <= RESP_TRIES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TOKEN_LIMIT: token_limit_reg <= cfg_data;
                CFG_RESP_TRIES:  resp_tries_reg  <= cfg_data[TRIES_W-1:0];
                default:         token_limit_reg <= token_limit_reg;
            endcase
        end
    end

    // Control: stage valids and engine state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_IDLE, default: '0};
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_move)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= '{req_type: req_type, first_block: first_block,
                             block_count: block_count, rx_byte: rx_byte};
        end
        if (s1_move && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // Engine step logic.
    sdr_core u_core (
        .state       (state_reg),
        .item        (s1_item_reg),
        .token_limit (token_limit_reg),
        .resp_tries  (resp_tries_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    // Output ports.
    assign out_valid    = out_valid_reg;
    assign send_valid   = result_reg.send_valid;
    assign send_byte    = result_reg.send_byte;
    assign select_level = result_reg.select_level;
    assign data_valid   = result_reg.data_valid;
    assign data_byte    = result_reg.data_byte;
    assign status       = result_reg.status;

    // Checks on the engine and its pipeline.
    `SDR_ASSERT_SAME(a_idle_deselect, out_valid_reg && !result_reg.send_valid,
        result_reg.select_level, "select asserted with nothing to send")
    `SDR_ASSERT_SAME(a_data_busy, out_valid_reg && result_reg.data_valid,
        result_reg.status == ST_BUSY && result_reg.send_valid, "data byte outside a busy transfer")
    `SDR_ASSERT_SAME(a_end_silent, out_valid_reg && result_reg.status != ST_BUSY,
        !result_reg.send_valid, "byte sent after completion or failure")
    `SDR_ASSERT_NEXT(a_stall_holds, s1_valid_reg && !s1_move,
        s1_valid_reg && $stable(state_reg), "engine state moved during a stall")

endmodule

// ===== hdl/sdr_core.sv =====
// Next-state and result logic of the SD card SPI read engine, one SPI byte per item.
// Depends on sdr_pkg.
module sdr_core
    import sdr_pkg::*;
(
    input  engine_state_t          state,
    input  req_item_t              item,
    input  logic [POLL_CNT_W-1:0]  token_limit,
    input  logic [TRIES_W-1:0]     resp_tries,
    output engine_state_t          state_next,
    output result_item_t           result
);

    localparam logic [BYTE_CNT_W:0] LAST_DATA = (BYTE_CNT_W+1)'(BLOCK_BYTES);

    always_comb
    begin
        logic [31:0]         left_dec;
        logic [BYTE_CNT_W:0] data_cnt_inc;

        left_dec     = state.blocks_left - 32'd1;
        data_cnt_inc = {1'b0, state.byte_cnt} + (BYTE_CNT_W+1)'(1);

        // Default: hold state, report an idle step.
        state_next          = state;
        result.send_valid   = 1'b0;
        result.send_byte    = 8'h00;
        result.select_level = 1'b1;
        result.data_valid   = 1'b0;
        result.data_byte    = 8'h00;
        result.status       = ST_BUSY;

        if (item.req_type == REQ_START)
        begin
            // A start aborts anything in flight and loads a new run.
            state_next.cur_block   = item.first_block;
            state_next.blocks_left = item.block_count;
            state_next.poll_cnt    = '0;
            if (item.block_count == 32'd0)
            begin
                state_next.phase    = PH_IDLE;
                state_next.byte_cnt = '0;
                result.status       = ST_DONE;
            end
            else
            begin
                state_next.phase    = PH_CMD;
                state_next.byte_cnt = CMD_ADDR_B3;
                result.send_valid   = 1'b1;
                result.send_byte    = CMD17_BYTE;
                result.select_level = 1'b0;
            end
        end
        else
        begin
            case (state.phase)
                PH_CMD:
                begin
                    result.send_valid   = 1'b1;
                    result.select_level = 1'b0;
                    result.send_byte    = DUMMY_BYTE;
                    state_next.byte_cnt = state.byte_cnt + BYTE_CNT_W'(1);
                    case (state.byte_cnt)
                        CMD_ADDR_B3: result.send_byte = state.cur_block[31:24];
                        CMD_ADDR_B2: result.send_byte = state.cur_block[23:16];
                        CMD_ADDR_B1: result.send_byte = state.cur_block[15:8];
                        CMD_ADDR_B0: result.send_byte = state.cur_block[7:0];
                        CMD_CRC:     result.send_byte = DUMMY_BYTE;
                        default:
                        begin
                            // Frame sent: first response poll.
                            state_next.byte_cnt = state.byte_cnt;
                            state_next.phase    = PH_RESP;
                            state_next.poll_cnt = POLL_CNT_W'(1);
                        end
                    endcase
                end
                PH_RESP:
                begin
                    if (!item.rx_byte[7] && item.rx_byte == 8'h00)
                    begin
                        state_next.phase    = PH_TOKEN;
                        state_next.poll_cnt = POLL_CNT_W'(1);
                        result.send_valid   = 1'b1;
                        result.send_byte    = DUMMY_BYTE;
                        result.select_level = 1'b0;
                    end
                    else if (item.rx_byte[7]
                             && state.poll_cnt < {{(POLL_CNT_W-TRIES_W){1'b0}}, resp_tries})
                    begin
                        state_next.poll_cnt = state.poll_cnt + POLL_CNT_W'(1);
                        result.send_valid   = 1'b1;
                        result.send_byte    = DUMMY_BYTE;
                        result.select_level = 1'b0;
                    end
                    else
                    begin
                        // Error response or tries exhausted.
                        state_next.phase    = PH_IDLE;
                        state_next.byte_cnt = '0;
                        state_next.poll_cnt = '0;
                        result.status       = ST_REJECT;
                    end
                end
                PH_TOKEN:
                begin
                    result.send_valid   = 1'b1;
                    result.send_byte    = DUMMY_BYTE;
                    result.select_level = 1'b0;
                    if (item.rx_byte == DATA_TOKEN)
                    begin
                        state_next.phase    = PH_DATA;
                        state_next.byte_cnt = '0;
                        state_next.poll_cnt = '0;
                    end
                    else if (state.poll_cnt < token_limit)
                    begin
                        state_next.poll_cnt = state.poll_cnt + POLL_CNT_W'(1);
                    end
                    else
                    begin
                        state_next.phase    = PH_IDLE;
                        state_next.byte_cnt = '0;
                        state_next.poll_cnt = '0;
                        result.send_valid   = 1'b0;
                        result.send_byte    = 8'h00;
                        result.select_level = 1'b1;
                        result.status       = ST_TIMEOUT;
                    end
                end
                PH_DATA:
                begin
                    // Pass each block byte on and keep clocking.
                    if (data_cnt_inc >= LAST_DATA)
                    begin
                        state_next.phase    = PH_CRC;
                        state_next.byte_cnt = '0;
                    end
                    else
                    begin
                        state_next.byte_cnt = data_cnt_inc[BYTE_CNT_W-1:0];
                    end
                    result.send_valid   = 1'b1;
                    result.send_byte    = DUMMY_BYTE;
                    result.select_level = 1'b0;
                    result.data_valid   = 1'b1;
                    result.data_byte    = item.rx_byte;
                end
                PH_CRC:
                begin
                    // Two CRC bytes are dropped; select rises before cleanup.
                    result.send_valid = 1'b1;
                    result.send_byte  = DUMMY_BYTE;
                    if (state.byte_cnt == '0)
                    begin
                        state_next.byte_cnt = BYTE_CNT_W'(1);
                        result.select_level = 1'b0;
                    end
                    else
                    begin
                        state_next.phase    = PH_CLEAN;
                        state_next.byte_cnt = '0;
                        result.select_level = 1'b1;
                    end
                end
                PH_CLEAN:
                begin
                    state_next.blocks_left = left_dec;
                    state_next.cur_block   = state.cur_block + 32'd1;
                    state_next.poll_cnt    = '0;
                    if (left_dec == 32'd0)
                    begin
                        state_next.phase    = PH_IDLE;
                        state_next.byte_cnt = '0;
                        result.status       = ST_DONE;
                    end
                    else
                    begin
                        state_next.phase    = PH_CMD;
                        state_next.byte_cnt = CMD_ADDR_B3;
                        result.send_valid   = 1'b1;
                        result.send_byte    = CMD17_BYTE;
                        result.select_level = 1'b0;
                    end
                end
                default:
                begin
                    // Idle: received bytes are ignored.
                    state_next.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule
